>>> src/detection_row_decode_core_defines.svh
// assertion macros used by the port-level checker in drd_checker.sv
`ifndef DETECTION_ROW_DECODE_CORE_DEFINES_SVH
`define DETECTION_ROW_DECODE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("drd check failed");

// next-cycle implication, disabled while reset is asserted
`define DRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("drd check failed");

`endif

>>> src/drd_pkg.sv
// shared types and constants of the detection row decoder
package drd_pkg;

	localparam int BOX_VALUES = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SCORE_W    = 16;
	localparam int DIM_W      = 13;
	localparam int POS_W      = 12;
	localparam int CLASS_W    = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd2;

	localparam logic [SCORE_W-1:0] THRESHOLD_RESET    = 16'd16384;
	localparam logic [DIM_W-1:0]   FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RESET = 13'd480;
	localparam logic [DIM_W-1:0]   DIM_MAX            = 13'd4096;

	typedef struct packed {
		logic [SCORE_W-1:0] cx;
		logic [SCORE_W-1:0] cy;
		logic [SCORE_W-1:0] w;
		logic [SCORE_W-1:0] h;
		logic [SCORE_W-1:0] best;
		logic [CLASS_W-1:0] cls;
	} row_rec_t;

	function automatic logic [DIM_W-1:0] frame_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = 13'd1;
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> src/drd_front.sv
// front end: row position tracking, box capture and running argmax
module drd_front #(
	parameter int NUM_CLASSES = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [drd_pkg::SCORE_W-1:0]     sample,
	input  logic [drd_pkg::SCORE_W-1:0]     threshold,
	output logic                            push,
	output drd_pkg::row_rec_t               rec
);

	localparam int ROW_LEN = drd_pkg::BOX_VALUES + NUM_CLASSES;
	localparam int CNT_W   = $clog2(ROW_LEN);

	logic [CNT_W-1:0]                 pos_q;
	logic [drd_pkg::SCORE_W-1:0]      best_q;
	logic [drd_pkg::CLASS_W-1:0]      cls_q;
	logic [drd_pkg::SCORE_W-1:0]      box_q [drd_pkg::BOX_VALUES];

	logic                             in_box;
	logic                             last;
	logic                             better;
	logic [CNT_W-1:0]                 cls_raw;
	logic [drd_pkg::SCORE_W-1:0]      best_nxt;
	logic [drd_pkg::CLASS_W-1:0]      cls_nxt;

	assign in_box   = pos_q < CNT_W'(drd_pkg::BOX_VALUES);
	assign last     = pos_q == CNT_W'(ROW_LEN - 1);
	assign better   = sample > best_q;
	assign cls_raw  = pos_q - CNT_W'(drd_pkg::BOX_VALUES);
	assign best_nxt = better ? sample : best_q;
	assign cls_nxt  = better ? drd_pkg::CLASS_W'(cls_raw) : cls_q;

	assign push     = accept && last && (best_nxt > threshold);
	assign rec.cx   = box_q[0];
	assign rec.cy   = box_q[1];
	assign rec.w    = box_q[2];
	assign rec.h    = box_q[3];
	assign rec.best = best_nxt;
	assign rec.cls  = cls_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			best_q <= '0;
			cls_q  <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q  <= '0;
				best_q <= '0;
				cls_q  <= '0;
			end else begin
				pos_q <= pos_q + CNT_W'(1);
				if (!in_box) begin
					best_q <= best_nxt;
					cls_q  <= cls_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_box) begin
			box_q[pos_q[1:0]] <= sample;
		end
	end

endmodule

>>> src/drd_queue.sv
// short row queue between front end and back end
module drd_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  drd_pkg::row_rec_t wr_rec,
	output logic              full,
	output logic              not_empty,
	input  logic              pop,
	output drd_pkg::row_rec_t rd_rec
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	drd_pkg::row_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

>>> src/drd_back.sv
// back end: box scaling to pixels, clamping and output register
module drd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  drd_pkg::row_rec_t             q_rec,
	output logic                          q_pop,
	input  logic [drd_pkg::DIM_W-1:0]     fw,
	input  logic [drd_pkg::DIM_W-1:0]     fh,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [drd_pkg::POS_W-1:0]     box_left,
	output logic [drd_pkg::POS_W-1:0]     box_top,
	output logic [drd_pkg::DIM_W-1:0]     box_width,
	output logic [drd_pkg::DIM_W-1:0]     box_height,
	output logic [drd_pkg::SCORE_W-1:0]   best_score,
	output logic [drd_pkg::CLASS_W-1:0]   class_index
);

	localparam int NUM_W  = drd_pkg::SCORE_W + 1;
	localparam int PPOS_W = NUM_W + drd_pkg::DIM_W;
	localparam int PLEN_W = drd_pkg::SCORE_W + drd_pkg::DIM_W;
	localparam int RAW_W  = drd_pkg::DIM_W + 1;

	function automatic logic [NUM_W-1:0] pos_num(input logic [drd_pkg::SCORE_W-1:0] c,
		input logic [drd_pkg::SCORE_W-1:0] s);
		logic signed [NUM_W:0] num;
		num = $signed({1'b0, c, 1'b0}) - $signed({2'b00, s});
		return (num <= 0) ? '0 : num[NUM_W-1:0];
	endfunction

	function automatic logic [drd_pkg::POS_W+drd_pkg::DIM_W-1:0] axis_fin(
		input logic [PPOS_W-1:0] ppos, input logic [PLEN_W-1:0] plen,
		input logic [drd_pkg::DIM_W-1:0] dim);
		logic [RAW_W-1:0]          pos_raw;
		logic [RAW_W-1:0]          len_raw;
		logic [drd_pkg::DIM_W-1:0] dm1;
		logic [drd_pkg::DIM_W-1:0] pos;
		logic [drd_pkg::DIM_W-1:0] room;
		logic [drd_pkg::DIM_W-1:0] len;
		pos_raw = ppos[PPOS_W-1:16];
		len_raw = plen[PLEN_W-1:15];
		dm1     = dim - drd_pkg::DIM_W'(1);
		pos     = (pos_raw > {1'b0, dm1}) ? dm1 : pos_raw[drd_pkg::DIM_W-1:0];
		room    = dim - pos;
		len     = (len_raw > {1'b0, room}) ? room : len_raw[drd_pkg::DIM_W-1:0];
		return {pos[drd_pkg::POS_W-1:0], len};
	endfunction

	logic [drd_pkg::DIM_W-1:0]   dim_w;
	logic [drd_pkg::DIM_W-1:0]   dim_h;
	logic                        s1_ready;
	logic                        s2_ready;

	logic                        valid_s1;
	logic [PPOS_W-1:0]           ppos_x_s1;
	logic [PLEN_W-1:0]           plen_x_s1;
	logic [PPOS_W-1:0]           ppos_y_s1;
	logic [PLEN_W-1:0]           plen_y_s1;
	logic [drd_pkg::DIM_W-1:0]   dim_w_s1;
	logic [drd_pkg::DIM_W-1:0]   dim_h_s1;
	logic [drd_pkg::SCORE_W-1:0] best_s1;
	logic [drd_pkg::CLASS_W-1:0] cls_s1;

	logic                        valid_s2;

	assign dim_w    = drd_pkg::frame_dim(fw);
	assign dim_h    = drd_pkg::frame_dim(fh);
	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign q_pop    = q_valid && s1_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= q_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ppos_x_s1 <= PPOS_W'(pos_num(q_rec.cx, q_rec.w)) * PPOS_W'(dim_w);
			plen_x_s1 <= PLEN_W'(q_rec.w) * PLEN_W'(dim_w);
			ppos_y_s1 <= PPOS_W'(pos_num(q_rec.cy, q_rec.h)) * PPOS_W'(dim_h);
			plen_y_s1 <= PLEN_W'(q_rec.h) * PLEN_W'(dim_h);
			dim_w_s1  <= dim_w;
			dim_h_s1  <= dim_h;
			best_s1   <= q_rec.best;
			cls_s1    <= q_rec.cls;
		end
	end

	// clamp stage and output register
	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			{box_left, box_width} <= axis_fin(ppos_x_s1, plen_x_s1, dim_w_s1);
			{box_top, box_height} <= axis_fin(ppos_y_s1, plen_y_s1, dim_h_s1);
			best_score            <= best_s1;
			class_index           <= cls_s1;
		end
	end

endmodule

>>> src/detection_row_decode_core.sv
// top level of the detection row decoder
// after its row's last score transfer a box passes the row queue, the multiply stage and the output register
// throughput: one sample per cycle while in_stall is low; at most one box per 4 + NUM_CLASSES samples
// a two-entry row queue parts the sample front end from the two-stage scaling back end
// reset: asynchronous, clears row position, argmax, queue and pipeline valids
// reset also loads threshold 16384 and frame size 640 x 480
module detection_row_decode_core #(
	parameter int NUM_CLASSES = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [drd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [drd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [drd_pkg::SCORE_W-1:0]       sample_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [drd_pkg::POS_W-1:0]         box_left,
	output logic [drd_pkg::POS_W-1:0]         box_top,
	output logic [drd_pkg::DIM_W-1:0]         box_width,
	output logic [drd_pkg::DIM_W-1:0]         box_height,
	output logic [drd_pkg::SCORE_W-1:0]       best_score,
	output logic [drd_pkg::CLASS_W-1:0]       class_index
);

	logic [drd_pkg::SCORE_W-1:0] threshold_q;
	logic [drd_pkg::DIM_W-1:0]   frame_width_q;
	logic [drd_pkg::DIM_W-1:0]   frame_height_q;

	logic              accept;
	logic              push;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	drd_pkg::row_rec_t wr_rec;
	drd_pkg::row_rec_t rd_rec;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= drd_pkg::THRESHOLD_RESET;
			frame_width_q  <= drd_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= drd_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				drd_pkg::CFG_SCORE_THRESHOLD: begin
					threshold_q <= cfg_data;
				end
				drd_pkg::CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[drd_pkg::DIM_W-1:0];
				end
				drd_pkg::CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[drd_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	drd_front #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (sample_value),
		.threshold (threshold_q),
		.push      (push),
		.rec       (wr_rec)
	);

	drd_queue #(
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (wr_rec),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (q_pop),
		.rd_rec    (rd_rec)
	);

	drd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_rec       (rd_rec),
		.q_pop       (q_pop),
		.fw          (frame_width_q),
		.fh          (frame_height_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.box_left    (box_left),
		.box_top     (box_top),
		.box_width   (box_width),
		.box_height  (box_height),
		.best_score  (best_score),
		.class_index (class_index)
	);

endmodule

>>> src/drd_checker.sv
// port-level checker of the detection row decoder and its bind
`include "detection_row_decode_core_defines.svh"

module drd_checker #(
	parameter int NUM_CLASSES = 10
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [drd_pkg::POS_W-1:0]       box_left,
	input logic [drd_pkg::POS_W-1:0]       box_top,
	input logic [drd_pkg::DIM_W-1:0]       box_width,
	input logic [drd_pkg::DIM_W-1:0]       box_height,
	input logic [drd_pkg::SCORE_W-1:0]     best_score,
	input logic [drd_pkg::CLASS_W-1:0]     class_index
);

	localparam int SUM_W     = drd_pkg::DIM_W + 1;
	localparam int PAYLOAD_W = 2 * drd_pkg::POS_W + 2 * drd_pkg::DIM_W + drd_pkg::SCORE_W
		+ drd_pkg::CLASS_W;

	logic [PAYLOAD_W-1:0] payload;
	logic                 left_fits;
	logic                 top_fits;
	logic                 class_ok;

	assign payload   = {box_left, box_top, box_width, box_height, best_score, class_index};
	assign left_fits = (SUM_W'(box_left) + SUM_W'(box_width)) <= SUM_W'(drd_pkg::DIM_MAX);
	assign top_fits  = (SUM_W'(box_top) + SUM_W'(box_height)) <= SUM_W'(drd_pkg::DIM_MAX);
	assign class_ok  = class_index < drd_pkg::CLASS_W'(NUM_CLASSES);

	// a stalled result stays offered
	`DRD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a stalled result keeps its payload
	`DRD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(payload))

	// a box only leaves with a score above some threshold
	`DRD_ASSERT_IMPLY(a_score_nonzero, clk, arst_n, out_valid, best_score != '0)

	// box stays inside the largest frame and names a real class
	`DRD_ASSERT_IMPLY(a_box_in_range, clk, arst_n, out_valid, left_fits && top_fits && class_ok)

endmodule

bind detection_row_decode_core drd_checker #(
	.NUM_CLASSES(NUM_CLASSES)
) u_drd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.box_left    (box_left),
	.box_top     (box_top),
	.box_width   (box_width),
	.box_height  (box_height),
	.best_score  (best_score),
	.class_index (class_index)
);

>>> tb/detection_row_decode_checker.sv
// checker that predicts the decoded boxes from the observed transfers and compares them
module detection_row_decode_checker #(
	parameter int NUM_CLASSES = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [drd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [drd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [drd_pkg::SCORE_W-1:0]       sample_value,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [drd_pkg::POS_W-1:0]         box_left,
	input  logic [drd_pkg::POS_W-1:0]         box_top,
	input  logic [drd_pkg::DIM_W-1:0]         box_width,
	input  logic [drd_pkg::DIM_W-1:0]         box_height,
	input  logic [drd_pkg::SCORE_W-1:0]       best_score,
	input  logic [drd_pkg::CLASS_W-1:0]       class_index,
	output int                                mismatch_count,
	output int                                boxes_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import drd_pkg::*;

	localparam int ROW_LEN = BOX_VALUES + NUM_CLASSES;

	typedef struct packed {
		logic [POS_W-1:0]   left;
		logic [POS_W-1:0]   top;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [SCORE_W-1:0] score;
		logic [CLASS_W-1:0] cls;
	} box_t;

	logic [SCORE_W-1:0] thr_reg;
	logic [DIM_W-1:0]   fw_reg;
	logic [DIM_W-1:0]   fh_reg;
	int unsigned        row_pos;
	logic [SCORE_W-1:0] row_best;
	logic [CLASS_W-1:0] row_class;
	logic [SCORE_W-1:0] row_box [BOX_VALUES];
	box_t               boxes_due [$];

	// zero acts as one, anything above 4096 as 4096
	function automatic longint usable_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > 13'd4096) begin
			return 4096;
		end
		return longint'(v);
	endfunction

	// origin and extent along one axis from a Q1.15 centre and size
	function automatic void decode_axis(input logic [SCORE_W-1:0] centre,
			input logic [SCORE_W-1:0] size, input longint dim,
			output logic [DIM_W-1:0] origin, output logic [DIM_W-1:0] extent);
		longint span;
		longint pos;
		longint len;
		span = 2 * longint'(centre) - longint'(size);
		len = (longint'(size) * dim) / 32768;
		if (span <= 0) begin
			pos = 0;
		end else begin
			pos = (span * dim) / 65536;
			if (pos > dim - 1) begin
				pos = dim - 1;
			end
		end
		if (len > dim - pos) begin
			len = dim - pos;
		end
		origin = pos[DIM_W-1:0];
		extent = len[DIM_W-1:0];
	endfunction

	task automatic note_mismatch(input string what, input box_t want, input box_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: expected left %0d top %0d width %0d height %0d score %0d class %0d",
				$time, what, want.left, want.top, want.width, want.height, want.score, want.cls);
			$display("%0t %s: actual   left %0d top %0d width %0d height %0d score %0d class %0d",
				$time, what, got.left, got.top, got.width, got.height, got.score, got.cls);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		box_t got;
		box_t want;
		logic [DIM_W-1:0] org;
		logic [DIM_W-1:0] ext;
		if (!arst_n) begin
			thr_reg = THRESHOLD_RESET;
			fw_reg = FRAME_WIDTH_RESET;
			fh_reg = FRAME_HEIGHT_RESET;
			row_pos = 0;
			row_best = '0;
			row_class = '0;
			foreach (row_box[i]) row_box[i] = '0;
			boxes_due.delete();
		end else begin
			// box transfer
			if (out_valid && !out_stall) begin
				got.left = box_left;
				got.top = box_top;
				got.width = box_width;
				got.height = box_height;
				got.score = best_score;
				got.cls = class_index;
				if (boxes_due.size() == 0) begin
					note_mismatch("unexpected box", '0, got);
				end else begin
					want = boxes_due.pop_front();
					if (got !== want) begin
						note_mismatch("box mismatch", want, got);
					end
				end
			end
			// sample transfer
			if (in_valid && !in_stall) begin
				if (row_pos < BOX_VALUES) begin
					row_box[row_pos] = sample_value;
					row_pos++;
				end else begin
					if (sample_value > row_best) begin
						row_best = sample_value;
						row_class = CLASS_W'(row_pos - BOX_VALUES);
					end
					row_pos++;
					if (row_pos == ROW_LEN) begin
						if (row_best > thr_reg) begin
							decode_axis(row_box[0], row_box[2], usable_dim(fw_reg), org, ext);
							want.left = org[POS_W-1:0];
							want.width = ext;
							decode_axis(row_box[1], row_box[3], usable_dim(fh_reg), org, ext);
							want.top = org[POS_W-1:0];
							want.height = ext;
							want.score = row_best;
							want.cls = row_class;
							boxes_due = {boxes_due, want};
						end
						row_pos = 0;
						row_best = '0;
						row_class = '0;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_SCORE_THRESHOLD: thr_reg = cfg_data[SCORE_W-1:0];
					CFG_FRAME_WIDTH:     fw_reg = cfg_data[DIM_W-1:0];
					CFG_FRAME_HEIGHT:    fh_reg = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
		end
		boxes_pending = boxes_due.size();
	end

endmodule

>>> tb/tb.sv
// testbench top: drives detector rows and register writes into the decoder and gives the verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import drd_pkg::*;

	localparam int NUM_CLASSES    = 10;
	localparam int ROW_LEN        = BOX_VALUES + NUM_CLASSES;
	localparam int PHASES         = 12;
	localparam int ROWS_PER_PHASE = 7;
	localparam int SETTLE_CYCLES  = 10;
	localparam int IDLE_LIMIT     = 2000;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;
	typedef enum int {ROW_RANDOM, ROW_ZERO, ROW_TIED, ROW_NEAR} row_kind_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [SCORE_W-1:0]     sample_value = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [POS_W-1:0]       box_left;
	logic [POS_W-1:0]       box_top;
	logic [DIM_W-1:0]       box_width;
	logic [DIM_W-1:0]       box_height;
	logic [SCORE_W-1:0]     best_score;
	logic [CLASS_W-1:0]     class_index;

	int                     mismatch_count;
	int                     boxes_pending;
	int                     idle_cycles = 0;
	int                     burst_left = 0;
	int                     mode_left = 0;
	stall_kind_t            stall_mode = STALL_NONE;
	logic [SCORE_W-1:0]     thr_now = THRESHOLD_RESET;
	logic [SCORE_W-1:0]     row_buf [ROW_LEN];

	detection_row_decode_core #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_value(sample_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.box_left(box_left),
		.box_top(box_top),
		.box_width(box_width),
		.box_height(box_height),
		.best_score(best_score),
		.class_index(class_index)
	);

	detection_row_decode_checker #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_value(sample_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.box_left(box_left),
		.box_top(box_top),
		.box_width(box_width),
		.box_height(box_height),
		.best_score(best_score),
		.class_index(class_index),
		.mismatch_count(mismatch_count),
		.boxes_pending(boxes_pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_kind_t'($urandom_range(0, 3));
			mode_left = $urandom_range(32, 256);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
			default:     out_stall <= (mode_left % 5 < 2);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("detection_row_decode_core test failed");
			$finish;
		end
	end

	function automatic logic [SCORE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'($urandom_range(0, 255));
			4: return 16'hFFFF - 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [SCORE_W-1:0] near_threshold();
		case ($urandom_range(0, 2))
			0: return thr_now;
			1: return (thr_now == 16'hFFFF) ? thr_now : thr_now + 16'd1;
			default: return (thr_now == 16'h0000) ? thr_now : thr_now - 16'd1;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_dim();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(1, 64));
			default: return 16'($urandom_range(1, 4096));
		endcase
	endfunction

	// one sample transfer, with a random gap opening each burst
	task automatic send_sample(input logic [SCORE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_row();
		for (int i = 0; i < ROW_LEN; i++) begin
			send_sample(row_buf[i]);
		end
	endtask

	task automatic make_random_row();
		row_kind_t kind;
		logic [SCORE_W-1:0] peak;
		case ($urandom_range(0, 15))
			0: kind = ROW_ZERO;
			1: kind = ROW_TIED;
			2, 3: kind = ROW_NEAR;
			default: kind = ROW_RANDOM;
		endcase
		for (int i = 0; i < BOX_VALUES; i++) begin
			row_buf[i] = pick_value();
		end
		peak = pick_value();
		for (int i = BOX_VALUES; i < ROW_LEN; i++) begin
			case (kind)
				ROW_ZERO: row_buf[i] = '0;
				ROW_TIED: row_buf[i] = 16'($urandom_range(0, peak));
				ROW_NEAR: row_buf[i] = ($urandom_range(0, 1) == 0) ? near_threshold()
					: 16'($urandom_range(0, thr_now));
				default:  row_buf[i] = pick_value();
			endcase
		end
		// peak value placed at two randomly picked classes, which may coincide
		if (kind == ROW_TIED) begin
			row_buf[BOX_VALUES + $urandom_range(0, NUM_CLASSES - 1)] = peak;
			row_buf[BOX_VALUES + $urandom_range(0, NUM_CLASSES - 1)] = peak;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (boxes_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_SCORE_THRESHOLD) begin
			thr_now = data;
		end
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure_phase(input int p);
		case (p)
			0: begin
				write_reg(CFG_SCORE_THRESHOLD, 16'd0);
				write_reg(CFG_FRAME_WIDTH, 16'd1);
				write_reg(CFG_FRAME_HEIGHT, 16'd1);
			end
			1: begin
				write_reg(CFG_SCORE_THRESHOLD, 16'hFFFF);
				write_reg(CFG_FRAME_WIDTH, 16'd4096);
				write_reg(CFG_FRAME_HEIGHT, 16'd4096);
			end
			2: begin
				write_reg(CFG_SCORE_THRESHOLD, 16'd1);
				write_reg(CFG_FRAME_WIDTH, 16'd0);
				write_reg(CFG_FRAME_HEIGHT, 16'd0);
			end
			3: begin
				write_reg(CFG_SCORE_THRESHOLD, THRESHOLD_RESET);
				write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
				write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
				write_reg(CFG_UNUSED, 16'($urandom));
			end
			4: begin
				write_reg(CFG_SCORE_THRESHOLD, 16'd32767);
				write_reg(CFG_FRAME_WIDTH, 16'd4097);
				write_reg(CFG_FRAME_HEIGHT, 16'd4095);
			end
			5: begin
				write_reg(CFG_SCORE_THRESHOLD, THRESHOLD_RESET);
				write_reg(CFG_FRAME_WIDTH, 16'(FRAME_WIDTH_RESET));
				write_reg(CFG_FRAME_HEIGHT, 16'(FRAME_HEIGHT_RESET));
			end
			default: begin
				write_reg(CFG_SCORE_THRESHOLD, 16'($urandom_range(0, 50000)));
				write_reg(CFG_FRAME_WIDTH, random_dim());
				write_reg(CFG_FRAME_HEIGHT, random_dim());
			end
		endcase
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// box hanging off the left and bottom edges, last class wins
		row_buf[0] = 16'h0000;
		row_buf[1] = 16'hFFFF;
		row_buf[2] = 16'hFFFF;
		row_buf[3] = 16'h0000;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			row_buf[BOX_VALUES + i] = 16'(i * 6000);
		end
		row_buf[ROW_LEN - 1] = 16'hFFFF;
		send_row();

		// all scores zero, no box
		row_buf[0] = 16'hFFFF;
		row_buf[1] = 16'h8000;
		row_buf[2] = 16'h0001;
		row_buf[3] = 16'h7FFF;
		for (int i = BOX_VALUES; i < ROW_LEN; i++) begin
			row_buf[i] = '0;
		end
		send_row();

		for (int p = 0; p < PHASES; p++) begin
			settle();
			configure_phase(p);
			for (int r = 0; r < ROWS_PER_PHASE; r++) begin
				make_random_row();
				send_row();
			end
		end
		settle();

		if (mismatch_count == 0 && boxes_pending == 0) begin
			$display("detection_row_decode_core test passed");
		end else begin
			$display("detection_row_decode_core test failed");
		end
		$finish;
	end

endmodule
